FILE: rtl/rsia_pkg.sv
package rsia_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int COUNT_BITS  = 32;
    localparam int FRAC_BITS   = 16;

    localparam int WIDE_BITS   = 128;
    localparam int STEP_BITS   = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic               valid;
        logic signed [63:0] value;
    } rsia_queue_t;

endpackage

FILE: rtl/rsia_if.sv
interface rsia_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rsia_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        sample_count;
    logic signed [63:0] running_sum;
    logic [62:0]        running_sum_sq;
    logic signed [47:0] mean_q16;
    logic               mean_valid;
    logic [62:0]        variance_int;
    logic [47:0]        stdev_q16;
    logic               variance_valid;
    logic               overflow_seen;

    modport source (output valid, output sample_count, output running_sum,
                    output running_sum_sq, output mean_q16, output mean_valid,
                    output variance_int, output stdev_q16, output variance_valid,
                    output overflow_seen, input ready);
    modport sink   (input valid, input sample_count, input running_sum,
                    input running_sum_sq, input mean_q16, input mean_valid,
                    input variance_int, input stdev_q16, input variance_valid,
                    input overflow_seen, output ready);
endinterface

FILE: rtl/running_stats_integer_accumulator.sv
// Running mean and sample variance of a signed integer stream. Every
// transaction on the sample channel adds one sample to a saturating count,
// sum and sum of squares and yields one transaction on the result channel
// with the totals, the Q.16 mean, the n-1 sample variance and the Q.16
// standard deviation; mean_valid and variance_valid stand in for the
// undefined cases, and overflow_seen is a sticky saturation flag. An input
// queue of two entries takes samples while the back end is busy. The back
// end works one sample at a time: two serial multiplies, a bit-serial mean
// divide, then for n >= 2 a bit-serial variance divide and a square root,
// then a handoff to the result register. It takes no new sample until it
// has loaded the result of the last one into the output register.
module running_stats_integer_accumulator (
    input  logic       clk,
    input  logic       rst_n,
    rsia_in_if.sink    samples,
    rsia_out_if.source results
);

    rsia_pkg::rsia_queue_t q;   // queued sample toward the back end
    logic                  q_ready;

    // front: accept and sign-extend, buffer
    rsia_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .q_out   (q),
        .q_ready (q_ready)
    );

    // back: accumulate, then serial multiply, divide and square root
    rsia_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_in    (q),
        .q_ready (q_ready),
        .results (results)
    );

endmodule

FILE: rtl/rsia_front.sv
module rsia_front (
    input  logic                 clk,
    input  logic                 rst_n,
    rsia_in_if.sink              samples,
    output rsia_pkg::rsia_queue_t q_out,
    input  logic                 q_ready
);

    logic signed [63:0] entry_reg [rsia_pkg::QUEUE_DEPTH];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         fill_reg;
    logic [1:0]         fill_next;
    logic               push;
    logic               pop;
    logic signed [63:0] ext_value;

    // sign-extend the low SAMPLE_BITS of the sample
    assign ext_value = 64'(signed'(samples.sample[rsia_pkg::SAMPLE_BITS-1:0]));

    assign samples.ready = (fill_reg != 2'(rsia_pkg::QUEUE_DEPTH));
    assign push          = samples.valid && samples.ready;
    assign pop           = q_out.valid && q_ready;
    assign q_out.valid   = (fill_reg != 2'd0);
    assign q_out.value   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= ext_value;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 2'(rsia_pkg::QUEUE_DEPTH))
        else $error("queue over depth");
`endif

endmodule

FILE: rtl/rsia_back.sv
module rsia_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rsia_pkg::rsia_queue_t q_in,
    output logic                  q_ready,
    rsia_out_if.source            results
);

    localparam int CB = rsia_pkg::COUNT_BITS;
    localparam int SB = rsia_pkg::SAMPLE_BITS;
    localparam int WB = rsia_pkg::WIDE_BITS;
    localparam int FB = rsia_pkg::FRAC_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_PREP = 4'd3;
    localparam logic [3:0] S_MULA = 4'd4;
    localparam logic [3:0] S_MULB = 4'd5;
    localparam logic [3:0] S_DIFF = 4'd6;
    localparam logic [3:0] S_DIVM = 4'd7;
    localparam logic [3:0] S_DIVV = 4'd8;
    localparam logic [3:0] S_SQRT = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]                 state_reg;
    logic [rsia_pkg::STEP_BITS-1:0] step_reg;
    logic signed [63:0]         x_reg;
    logic [62:0]                sq_reg;
    logic [CB-1:0]              count_reg;
    logic signed [63:0]         sum_reg;
    logic [62:0]                sum_sq_reg;
    logic                       overflow_reg;
    logic [63:0]                mag_reg;
    logic                       neg_reg;
    logic [63:0]                den_reg;
    logic [WB-1:0]              acc_reg;
    logic [WB-1:0]              mcand_reg;
    logic [63:0]                mplier_reg;
    logic [WB-1:0]              prod_a_reg;
    logic [WB-1:0]              num_reg;
    logic [WB-1:0]              dvd_reg;
    logic [63:0]                rem_reg;
    logic [63:0]                dsr_reg;
    logic [67:0]                srem_reg;
    logic [63:0]                root_reg;
    logic signed [47:0]         mean_reg;
    logic [62:0]                var_reg;

    logic                       out_valid_reg;
    logic [31:0]                o_count_reg;
    logic signed [63:0]         o_sum_reg;
    logic [62:0]                o_sum_sq_reg;
    logic signed [47:0]         o_mean_reg;
    logic                       o_mean_valid_reg;
    logic [62:0]                o_var_reg;
    logic [47:0]                o_sd_reg;
    logic                       o_var_valid_reg;
    logic                       o_ovf_reg;

    logic [SB-1:0]              ax;
    logic [2*SB-1:0]            sq_prod;
    logic [64:0]                sum_ext;
    logic [63:0]                sq_sum;
    logic [WB-1:0]              acc_next;
    logic [64:0]                rem_sh;
    logic                       div_ge;
    logic [63:0]                rem_next;
    logic [WB-1:0]              dvd_next;
    logic [67:0]                srem_sh;
    logic [67:0]                trial;
    logic                       sqrt_ge;
    logic [63:0]                root_next;
    logic [WB-1:0]              mean_lim;
    logic [47:0]                mean_mag;
    logic [WB-1:0]              var_q;
    logic [2*CB-1:0]            den_prod;
    logic                       last_step;
    logic                       out_free;

    assign ax        = x_reg[63] ? SB'(-x_reg) : x_reg[SB-1:0];
    assign sq_prod   = ax * ax;
    assign sum_ext   = {sum_reg[63], sum_reg} + {x_reg[63], x_reg};
    assign sq_sum    = {1'b0, sum_sq_reg} + {1'b0, sq_reg};
    assign acc_next  = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
    assign den_prod  = count_reg * (count_reg - CB'(1));

    // restoring divide, one quotient bit per cycle
    assign rem_sh    = {rem_reg, dvd_reg[WB-1]};
    assign div_ge    = rem_sh >= {1'b0, dsr_reg};
    assign rem_next  = div_ge ? 64'(rem_sh - {1'b0, dsr_reg}) : rem_sh[63:0];
    assign dvd_next  = {dvd_reg[WB-2:0], div_ge};

    // restoring square root, one root bit per cycle
    assign srem_sh   = {srem_reg[65:0], dvd_reg[WB-1:WB-2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign sqrt_ge   = srem_sh >= trial;
    assign root_next = {root_reg[62:0], sqrt_ge};

    assign mean_lim  = neg_reg ? WB'(64'h0000_8000_0000_0000) : WB'(64'h0000_7FFF_FFFF_FFFF);
    assign mean_mag  = (dvd_next > mean_lim) ? mean_lim[47:0] : dvd_next[47:0];
    assign var_q     = dvd_next >> (2 * FB);
    assign last_step = (step_reg == rsia_pkg::STEP_BITS'(1));
    assign out_free  = !out_valid_reg || results.ready;
    assign q_ready   = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            sum_sq_reg    <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_in.valid)
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (count_reg == '1)
                    begin
                        overflow_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + CB'(1);
                        if (sum_ext[64] != sum_ext[63])
                        begin
                            sum_reg      <= sum_ext[64] ? 64'sh8000_0000_0000_0000
                                                        : 64'sh7FFF_FFFF_FFFF_FFFF;
                            overflow_reg <= 1'b1;
                        end
                        else
                        begin
                            sum_reg <= sum_ext[63:0];
                        end
                        if (sq_sum[63])
                        begin
                            sum_sq_reg   <= '1;
                            overflow_reg <= 1'b1;
                        end
                        else
                        begin
                            sum_sq_reg <= sq_sum[62:0];
                        end
                    end
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    step_reg  <= rsia_pkg::STEP_BITS'(CB);
                    state_reg <= S_MULA;
                end
                S_MULA:
                begin
                    if (last_step)
                    begin
                        step_reg  <= rsia_pkg::STEP_BITS'(64);
                        state_reg <= S_MULB;
                    end
                    else
                    begin
                        step_reg <= step_reg - rsia_pkg::STEP_BITS'(1);
                    end
                end
                S_MULB:
                begin
                    step_reg <= step_reg - rsia_pkg::STEP_BITS'(1);
                    if (last_step)
                    begin
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    step_reg  <= rsia_pkg::STEP_BITS'(WB);
                    state_reg <= S_DIVM;
                end
                S_DIVM:
                begin
                    if (last_step)
                    begin
                        if (count_reg >= CB'(2))
                        begin
                            step_reg  <= rsia_pkg::STEP_BITS'(WB);
                            state_reg <= S_DIVV;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg - rsia_pkg::STEP_BITS'(1);
                    end
                end
                S_DIVV:
                begin
                    if (last_step)
                    begin
                        step_reg  <= rsia_pkg::STEP_BITS'(64);
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        step_reg <= step_reg - rsia_pkg::STEP_BITS'(1);
                    end
                end
                S_SQRT:
                begin
                    step_reg <= step_reg - rsia_pkg::STEP_BITS'(1);
                    if (last_step)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_in.valid)
                begin
                    x_reg <= q_in.value;
                end
            end
            S_SQ:
            begin
                sq_reg <= 63'(sq_prod);
            end
            S_PREP:
            begin
                mag_reg    <= sum_reg[63] ? 64'(-sum_reg) : sum_reg;
                neg_reg    <= sum_reg[63];
                den_reg    <= 64'(den_prod);
                acc_reg    <= '0;
                mcand_reg  <= WB'(sum_sq_reg);
                mplier_reg <= 64'(count_reg);
            end
            S_MULA:
            begin
                if (last_step)
                begin
                    prod_a_reg <= acc_next;
                    acc_reg    <= '0;
                    mcand_reg  <= WB'(mag_reg);
                    mplier_reg <= mag_reg;
                end
                else
                begin
                    acc_reg    <= acc_next;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
            S_MULB:
            begin
                acc_reg    <= acc_next;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            S_DIFF:
            begin
                // a negative numerator only follows saturation; clamp to zero
                num_reg <= (acc_reg <= prod_a_reg) ? prod_a_reg - acc_reg : '0;
                dvd_reg <= WB'(mag_reg) << FB;
                dsr_reg <= 64'(count_reg);
                rem_reg <= '0;
                var_reg <= '0;
                root_reg <= '0;
            end
            S_DIVM:
            begin
                if (last_step)
                begin
                    mean_reg <= neg_reg ? 48'(-mean_mag) : mean_mag;
                    dvd_reg  <= num_reg << (2 * FB);
                    dsr_reg  <= den_reg;
                    rem_reg  <= '0;
                end
                else
                begin
                    dvd_reg <= dvd_next;
                    rem_reg <= rem_next;
                end
            end
            S_DIVV:
            begin
                dvd_reg <= dvd_next;
                if (last_step)
                begin
                    var_reg  <= (|var_q[WB-1:63]) ? '1 : var_q[62:0];
                    srem_reg <= '0;
                    root_reg <= '0;
                end
                else
                begin
                    rem_reg <= rem_next;
                end
            end
            S_SQRT:
            begin
                srem_reg <= sqrt_ge ? srem_sh - trial : srem_sh;
                root_reg <= root_next;
                dvd_reg  <= dvd_reg << 2;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    o_count_reg      <= 32'(count_reg);
                    o_sum_reg        <= sum_reg;
                    o_sum_sq_reg     <= sum_sq_reg;
                    o_mean_reg       <= mean_reg;
                    o_mean_valid_reg <= (count_reg != '0);
                    o_var_reg        <= var_reg;
                    o_sd_reg         <= (|root_reg[63:48]) ? '1 : root_reg[47:0];
                    o_var_valid_reg  <= (count_reg >= CB'(2));
                    o_ovf_reg        <= overflow_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign results.valid          = out_valid_reg;
    assign results.sample_count   = o_count_reg;
    assign results.running_sum    = o_sum_reg;
    assign results.running_sum_sq = o_sum_sq_reg;
    assign results.mean_q16       = o_mean_reg;
    assign results.mean_valid     = o_mean_valid_reg;
    assign results.variance_int   = o_var_reg;
    assign results.stdev_q16      = o_sd_reg;
    assign results.variance_valid = o_var_valid_reg;
    assign results.overflow_seen  = o_ovf_reg;

`ifndef NO_ASSERTIONS
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared");
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= $past(count_reg))
        else $error("count went down");
    a_mean_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> o_mean_valid_reg)
        else $error("result with empty aggregate");
`endif

endmodule
